### rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
    localparam logic [OP_W-1:0] OP_PRINT = 3'd1;
    localparam logic [OP_W-1:0] OP_CR    = 3'd2;
    localparam logic [OP_W-1:0] OP_LF    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OP_W-1:0] OP_READ  = 3'd5;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7F;

    localparam logic [7:0]  RESET_ATTR  = 8'h0F;
    localparam logic [15:0] RESET_BLANK = {RESET_ATTR, CHAR_SPACE};

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      char_code;
        logic [10:0]     cell_address;
    } tcw_entry_t;

    typedef struct packed {
        logic       valid;
        tcw_entry_t entry;
    } tcw_queue_t;

endpackage

### rtl/text_console_writer.sv
// print, cr, lf, ignored bytes and no-op: queue register, then the result registers
// read: adds a registered screen ram read; an out-of-range address returns zero data
// clear: one cell blanked per cycle
// scroll: one cell moved or blanked per cycle, then a result with scrolled set
// throughput: one simple transaction per cycle when out_ready, via a 2-entry queue
// reset: cursor homed, then a pass blanks the screen with the reset attribute, in_ready low
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] cursor_position,
    output logic [15:0] cell_data,
    output logic        scrolled
);

    logic [7:0]  text_attribute_reg, text_attribute_next;
    tcw_queue_t  q;
    logic        q_pop;
    logic        init_busy;

    assign text_attribute_next = cfg_write_en ? cfg_write_data : text_attribute_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attribute_reg <= RESET_ATTR;
        end
        else
        begin
            text_attribute_reg <= text_attribute_next;
        end
    end

    tcw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .char_code    (char_code),
        .cell_address (cell_address),
        .init_busy    (init_busy),
        .q            (q),
        .q_pop        (q_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_attribute  (text_attribute_reg),
        .q               (q),
        .q_pop           (q_pop),
        .init_busy       (init_busy),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_position (cursor_position),
        .cell_data       (cell_data),
        .scrolled        (scrolled)
    );

endmodule

### rtl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/tcw_front.sv
module tcw_front
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_address,
    input  logic        init_busy,
    output tcw_queue_t  q,
    input  logic        q_pop
);

    tcw_entry_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]         count_reg, count_next;
    logic                    push;
    tcw_entry_t              decoded;

    always_comb
    begin
        decoded.char_code    = char_code;
        decoded.cell_address = cell_address;
        case (command)
            CMD_WRITE:
            begin
                if (char_code == CHAR_CR)
                begin
                    decoded.op = OP_CR;
                end
                else if (char_code == CHAR_LF)
                begin
                    decoded.op = OP_LF;
                end
                else if (char_code >= CHAR_SPACE && char_code <= CHAR_LAST)
                begin
                    decoded.op = OP_PRINT;
                end
                else
                begin
                    decoded.op = OP_NOP;
                end
            end
            CMD_CLEAR: decoded.op = OP_CLEAR;
            CMD_READ:  decoded.op = OP_READ;
            default:   decoded.op = OP_NOP;
        endcase
    end

    assign in_ready = (count_reg != (QPTR_W+1)'(QDEPTH)) && !init_busy;
    assign push     = in_valid && in_ready;

    assign q.valid = (count_reg != '0);
    assign q.entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

### rtl/tcw_back.sv
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  text_attribute,
    input  tcw_queue_t  q,
    output logic        q_pop,
    output logic        init_busy,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] cursor_position,
    output logic [15:0] cell_data,
    output logic        scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;
    localparam logic [1:0] S_FILL = 2'd3;

    localparam logic [1:0] FILL_INIT   = 2'd0;
    localparam logic [1:0] FILL_CLEAR  = 2'd1;
    localparam logic [1:0] FILL_SCROLL = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW:0]      idx_reg, idx_next;
    logic [AW-1:0]    dst_reg, dst_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [10:0]      cursor_reg, cursor_next;
    logic [15:0]      data_reg, data_next;
    logic             scrolled_reg, scrolled_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [15:0]      wr_data;
    logic [AW-1:0]    rd_addr;
    logic [15:0]      rd_data;

    logic             slot_free;
    logic             load;
    logic [15:0]      load_data;
    logic             load_scrolled;
    logic             col_last;
    logic             row_last;
    logic [AW-1:0]    line_start;
    logic [AW+10:0]   addr_wide;
    logic [AW+10:0]   pos_wide;
    logic             addr_ok;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free  = !out_valid_reg || out_ready;
    assign col_last   = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last   = (row_reg == ROW_W'(ROWS - 1));
    assign line_start = pos_reg - {{(AW-COL_W){1'b0}}, col_reg};
    assign addr_wide  = {{AW{1'b0}}, q.entry.cell_address};
    assign addr_ok    = (int'(q.entry.cell_address) < CELLS);
    assign init_busy  = (state_reg == S_FILL) && (mode_reg == FILL_INIT);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = {text_attribute, q.entry.char_code};
        rd_addr        = addr_wide[AW-1:0];
        load           = 1'b0;
        load_data      = '0;
        load_scrolled  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q.valid && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q.entry.op)
                        OP_PRINT:
                        begin
                            wr_en = 1'b1;
                            if (!col_last)
                            begin
                                col_next = col_reg + 1'b1;
                                pos_next = pos_reg + 1'b1;
                                load     = 1'b1;
                            end
                            else if (!row_last)
                            begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                                pos_next = pos_reg + 1'b1;
                                load     = 1'b1;
                            end
                            else
                            begin
                                col_next   = '0;
                                pos_next   = AW'((ROWS - 1) * COLUMNS);
                                idx_next   = (AW+1)'(COLUMNS);
                                pend_next  = 1'b0;
                                state_next = S_COPY;
                            end
                        end
                        OP_LF:
                        begin
                            col_next = '0;
                            if (!row_last)
                            begin
                                row_next = row_reg + 1'b1;
                                pos_next = line_start + AW'(COLUMNS);
                                load     = 1'b1;
                            end
                            else
                            begin
                                pos_next   = AW'((ROWS - 1) * COLUMNS);
                                idx_next   = (AW+1)'(COLUMNS);
                                pend_next  = 1'b0;
                                state_next = S_COPY;
                            end
                        end
                        OP_CR:
                        begin
                            col_next = '0;
                            pos_next = line_start;
                            load     = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            pos_next   = '0;
                            idx_next   = '0;
                            mode_next  = FILL_CLEAR;
                            state_next = S_FILL;
                        end
                        OP_READ:
                        begin
                            if (addr_ok)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                load       = 1'b1;
                load_data  = rd_data;
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                // move each cell up one row, writing it in the cycle after its read
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data;
                end
                if (idx_reg != (AW+1)'(CELLS))
                begin
                    rd_addr   = idx_reg[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = idx_reg[AW-1:0] - AW'(COLUMNS);
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    idx_next   = (AW+1)'(CELLS - COLUMNS);
                    mode_next  = FILL_SCROLL;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_data  = (mode_reg == FILL_INIT) ? RESET_BLANK
                                                   : {text_attribute, CHAR_SPACE};
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (AW+1)'(CELLS - 1))
                begin
                    state_next    = S_IDLE;
                    load          = (mode_reg != FILL_INIT);
                    load_scrolled = (mode_reg == FILL_SCROLL);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        pos_wide       = {{11{1'b0}}, pos_next};
        out_valid_next = out_valid_reg && !out_ready;
        cursor_next    = cursor_reg;
        data_next      = data_reg;
        scrolled_next  = scrolled_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            cursor_next    = pos_wide[10:0];
            data_next      = load_data;
            scrolled_next  = load_scrolled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            mode_reg      <= FILL_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg      <= dst_next;
        cursor_reg   <= cursor_next;
        data_reg     <= data_next;
        scrolled_reg <= scrolled_next;
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = cursor_reg;
    assign cell_data       = data_reg;
    assign scrolled        = scrolled_reg;

`ifndef SYNTH
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= COL_W'(COLUMNS - 1)) && (row_reg <= ROW_W'(ROWS - 1)))
        else $error("cursor out of range");

    a_cursor_linear: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) == int'(row_reg) * COLUMNS + int'(col_reg))
        else $error("linear cursor disagrees with row and column");

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!out_valid_reg || out_ready))
        else $error("transaction started while result slot is held");

    a_scroll_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && mode_reg == FILL_SCROLL
            && idx_reg == (AW+1)'(CELLS - 1))
        |=> (out_valid_reg && scrolled_reg && state_reg == S_IDLE))
        else $error("scroll finished without a scrolled result");
`endif

endmodule
